[rtl/core/assert_macros.svh]
// Assertion helpers shared by the RTL. Both forms sample on clk and are
// disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CSG_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define CSG_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/csg_pkg.sv]
package csg_pkg;

  // Field widths
  localparam int PIXEL_W  = 16;
  localparam int GRAY_W   = 8;
  localparam int INDEX_W  = 17;
  localparam int STRIDE_W = 11;

  // Output coordinates are carried at a width that holds the largest output size
  localparam int OUT_COORD_W = 8;

  // Q16 luminance of one pixel, and the sum of four of them
  localparam int LUMA_W = 24;
  localparam int SUM_W  = 26;

  localparam logic [STRIDE_W-1:0] STRIDE_RESET = STRIDE_W'(96);

  // Default geometry
  localparam int CAPTURE_WIDTH_DEF     = 320;
  localparam int CAPTURE_HEIGHT_DEF    = 240;
  localparam int OUT_SIZE_DEF          = 96;
  localparam int CROP_LEFT_DEF         = 40;
  localparam int CROP_RIGHT_MARGIN_DEF = 80;

  // One 2x2 window that produces a result
  typedef struct packed {
    logic [PIXEL_W-1:0]     pix;
    logic [PIXEL_W-1:0]     left;
    logic [PIXEL_W-1:0]     upper_left;
    logic [OUT_COORD_W-1:0] out_row;
    logic [OUT_COORD_W-1:0] out_col;
    logic                   last;
  } csg_win_t;

  // Four luminance values plus the result tag
  typedef struct packed {
    logic [3:0][LUMA_W-1:0] luma;
    logic [INDEX_W-1:0]     index;
    logic                   last;
  } csg_lum_t;

endpackage

[rtl/core/csg_pixel_if.sv]
interface csg_pixel_if import csg_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [PIXEL_W-1:0] pixel;
  logic               frame_start;

  modport source (output valid, pixel, frame_start, input ready);
  modport sink   (input valid, pixel, frame_start, output ready);
endinterface

[rtl/core/csg_gray_if.sv]
interface csg_gray_if import csg_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [GRAY_W-1:0]  gray;
  logic [INDEX_W-1:0] out_index;
  logic               last;

  modport source (output valid, gray, out_index, last, input ready);
  modport sink   (input valid, gray, out_index, last, output ready);
endinterface

[rtl/core/csg_ram.sv]
module csg_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 320
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Read-first: a read and write to the same address return the old word
  always_ff @(posedge clk) begin
    if (re) begin
      rd_data_r <= mem[raddr];
    end
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  assign rdata = rd_data_r;

endmodule

[rtl/core/csg_front.sv]
module csg_front import csg_pkg::*; #(
  parameter int CAPTURE_WIDTH     = CAPTURE_WIDTH_DEF,
  parameter int CAPTURE_HEIGHT    = CAPTURE_HEIGHT_DEF,
  parameter int OUT_SIZE          = OUT_SIZE_DEF,
  parameter int CROP_LEFT         = CROP_LEFT_DEF,
  parameter int CROP_RIGHT_MARGIN = CROP_RIGHT_MARGIN_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  csg_pixel_if.sink          in_ch,
  input  logic               s2_en,
  output logic               s1_valid,
  output csg_win_t           s1_win,
  output logic [PIXEL_W-1:0] s1_above
);

  localparam int SPAN_RAW = CAPTURE_WIDTH - CROP_LEFT - CROP_RIGHT_MARGIN;
  localparam int SPAN     = (SPAN_RAW < 0) ? 0 : SPAN_RAW;
  localparam int COL_STEP = SPAN / OUT_SIZE;
  localparam int COL_FRAC = SPAN % OUT_SIZE;
  localparam int ROW_STEP = CAPTURE_HEIGHT / OUT_SIZE;
  localparam int ROW_FRAC = CAPTURE_HEIGHT % OUT_SIZE;

  localparam int COL_W   = $clog2(CAPTURE_WIDTH);
  localparam int ROW_W   = $clog2(CAPTURE_HEIGHT + 1);
  localparam int OC_W    = $clog2(OUT_SIZE);
  localparam int OR_W    = $clog2(OUT_SIZE + 1);
  localparam int CTGT_W  = $clog2(CAPTURE_WIDTH + 2);
  localparam int RTGT_W  = $clog2(CAPTURE_HEIGHT + 2);
  localparam int REM_W   = $clog2(OUT_SIZE);

  // Capture position and next output position
  logic [COL_W-1:0]   col_r, col_nxt, col_c;
  logic [ROW_W-1:0]   row_r, row_nxt, row_c;
  logic [OC_W-1:0]    ocol_r, ocol_nxt, ocol_c;
  logic [OR_W-1:0]    orow_r, orow_nxt, orow_c;
  // Sampled capture column/row of the next output, with division remainders
  logic [CTGT_W-1:0]  ctgt_r, ctgt_nxt, ctgt_c;
  logic [REM_W-1:0]   crem_r, crem_nxt, crem_c;
  logic [RTGT_W-1:0]  rtgt_r, rtgt_nxt, rtgt_c;
  logic [REM_W-1:0]   rrem_r, rrem_nxt, rrem_c;
  logic [PIXEL_W-1:0] left_r, left_nxt;
  logic               s1_valid_r;
  csg_win_t           s1_r;

  logic               s1_en;
  logic               acc;
  logic               emit;
  logic               last;
  logic               col_wrap;
  logic               ocol_wrap;
  logic [REM_W:0]     crem_sum, rrem_sum;
  logic               ccarry, rcarry;
  logic [PIXEL_W-1:0] above;

  assign s1_en       = !s1_valid_r || s2_en;
  assign in_ch.ready = s1_en;
  assign acc         = in_ch.valid && s1_en;

  // Frame start clears the position before the pixel is used
  always_comb begin
    if (in_ch.frame_start) begin
      col_c  = '0;
      row_c  = '0;
      ocol_c = '0;
      orow_c = '0;
      ctgt_c = CTGT_W'(CROP_LEFT);
      crem_c = '0;
      rtgt_c = '0;
      rrem_c = '0;
    end else begin
      col_c  = col_r;
      row_c  = row_r;
      ocol_c = ocol_r;
      orow_c = orow_r;
      ctgt_c = ctgt_r;
      crem_c = crem_r;
      rtgt_c = rtgt_r;
      rrem_c = rrem_r;
    end
  end

  // Window is complete when the lower-right pixel of the sample arrives
  assign emit = (orow_c < OR_W'(OUT_SIZE)) &&
                (CTGT_W'(col_c) == ctgt_c + CTGT_W'(1)) &&
                (RTGT_W'(row_c) == rtgt_c + RTGT_W'(1));
  assign last = (orow_c == OR_W'(OUT_SIZE - 1)) && (ocol_c == OC_W'(OUT_SIZE - 1));

  // Incremental x*span/N and y*H/N
  assign crem_sum = (REM_W+1)'(crem_c) + (REM_W+1)'(COL_FRAC);
  assign ccarry   = crem_sum >= (REM_W+1)'(OUT_SIZE);
  assign rrem_sum = (REM_W+1)'(rrem_c) + (REM_W+1)'(ROW_FRAC);
  assign rcarry   = rrem_sum >= (REM_W+1)'(OUT_SIZE);

  assign col_wrap  = col_c == COL_W'(CAPTURE_WIDTH - 1);
  assign ocol_wrap = ocol_c == OC_W'(OUT_SIZE - 1);

  // Position updates for an accepted pixel
  always_comb begin
    col_nxt  = col_r;
    row_nxt  = row_r;
    ocol_nxt = ocol_r;
    orow_nxt = orow_r;
    ctgt_nxt = ctgt_r;
    crem_nxt = crem_r;
    rtgt_nxt = rtgt_r;
    rrem_nxt = rrem_r;
    left_nxt = left_r;
    if (acc) begin
      col_nxt  = col_wrap ? '0 : col_c + COL_W'(1);
      row_nxt  = (col_wrap && row_c < ROW_W'(CAPTURE_HEIGHT)) ? row_c + ROW_W'(1) : row_c;
      ocol_nxt = ocol_c;
      orow_nxt = orow_c;
      ctgt_nxt = ctgt_c;
      crem_nxt = crem_c;
      rtgt_nxt = rtgt_c;
      rrem_nxt = rrem_c;
      left_nxt = in_ch.pixel;
      if (emit) begin
        if (ocol_wrap) begin
          ocol_nxt = '0;
          ctgt_nxt = CTGT_W'(CROP_LEFT);
          crem_nxt = '0;
          orow_nxt = orow_c + OR_W'(1);
          rtgt_nxt = rtgt_c + RTGT_W'(ROW_STEP) + RTGT_W'(rcarry);
          rrem_nxt = rcarry ? REM_W'(rrem_sum - (REM_W+1)'(OUT_SIZE)) : REM_W'(rrem_sum);
        end else begin
          ocol_nxt = ocol_c + OC_W'(1);
          ctgt_nxt = ctgt_c + CTGT_W'(COL_STEP) + CTGT_W'(ccarry);
          crem_nxt = ccarry ? REM_W'(crem_sum - (REM_W+1)'(OUT_SIZE)) : REM_W'(crem_sum);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r   <= '0;
      row_r   <= '0;
      ocol_r  <= '0;
      orow_r  <= '0;
      ctgt_r  <= CTGT_W'(CROP_LEFT);
      crem_r  <= '0;
      rtgt_r  <= '0;
      rrem_r  <= '0;
      left_r  <= '0;
    end else begin
      col_r   <= col_nxt;
      row_r   <= row_nxt;
      ocol_r  <= ocol_nxt;
      orow_r  <= orow_nxt;
      ctgt_r  <= ctgt_nxt;
      crem_r  <= crem_nxt;
      rtgt_r  <= rtgt_nxt;
      rrem_r  <= rrem_nxt;
      left_r  <= left_nxt;
    end
  end

  // Window register; the upper-row word lands in the line store read register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_en) begin
      s1_valid_r <= acc && emit;
    end
  end

  // Upper-left word is still in the read register from the previous pixel
  always_ff @(posedge clk) begin
    if (acc) begin
      s1_r.pix        <= in_ch.pixel;
      s1_r.left       <= left_r;
      s1_r.upper_left <= above;
      s1_r.out_row    <= OUT_COORD_W'(orow_c);
      s1_r.out_col    <= OUT_COORD_W'(ocol_c);
      s1_r.last       <= last;
    end
  end

  // Line store: read the word one row up, then overwrite it with this pixel
  csg_ram #(
    .WIDTH (PIXEL_W),
    .DEPTH (CAPTURE_WIDTH)
  ) u_line (
    .clk   (clk),
    .we    (acc),
    .waddr (col_c),
    .wdata (in_ch.pixel),
    .re    (acc),
    .raddr (col_c),
    .rdata (above)
  );

  assign s1_valid = s1_valid_r;
  assign s1_win   = s1_r;
  assign s1_above = above;

endmodule

[rtl/core/csg_luma.sv]
module csg_luma import csg_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                s1_valid,
  input  csg_win_t            s1_win,
  input  logic [PIXEL_W-1:0]  s1_above,
  input  logic [STRIDE_W-1:0] stride,
  input  logic                out_en,
  output logic                s2_en,
  output logic                s2_valid,
  output csg_lum_t            s2_lum
);

  localparam int PROD_W = OUT_COORD_W + STRIDE_W;
  localparam int W_RED   = 13933;
  localparam int W_GREEN = 46871;
  localparam int W_BLUE  = 4732;

  logic               s2_valid_r;
  csg_lum_t           s2_r;
  logic [PROD_W-1:0]  row_base;
  logic [PROD_W-1:0]  index_full;

  // Q16 luminance with R and B scaled by 8 and G by 4
  function automatic logic [LUMA_W-1:0] luma_q16(input logic [PIXEL_W-1:0] p);
    logic [LUMA_W-1:0] rb;
    logic [LUMA_W-1:0] g;
    rb = LUMA_W'(p[15:11]) * LUMA_W'(W_RED) + LUMA_W'(p[4:0]) * LUMA_W'(W_BLUE);
    g  = LUMA_W'(p[10:5]) * LUMA_W'(W_GREEN);
    return (rb << 3) + (g << 2);
  endfunction

  assign s2_en = !s2_valid_r || out_en;

  // Output index, kept to 17 bits
  assign row_base   = PROD_W'(s1_win.out_row) * PROD_W'(stride);
  assign index_full = row_base + PROD_W'(s1_win.out_col);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (s2_en) begin
      s2_valid_r <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_en && s1_valid) begin
      s2_r.luma[0] <= luma_q16(s1_win.upper_left);
      s2_r.luma[1] <= luma_q16(s1_above);
      s2_r.luma[2] <= luma_q16(s1_win.left);
      s2_r.luma[3] <= luma_q16(s1_win.pix);
      s2_r.index   <= index_full[INDEX_W-1:0];
      s2_r.last    <= s1_win.last;
    end
  end

  assign s2_valid = s2_valid_r;
  assign s2_lum   = s2_r;

endmodule

[rtl/core/csg_out.sv]
module csg_out import csg_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       s2_valid,
  input  csg_lum_t   s2_lum,
  output logic       out_en,
  csg_gray_if.source out_ch
);

  localparam int GRAY_SHIFT  = 18;
  localparam int GRAY_OFFSET = 128;
  localparam logic [SUM_W:0] OFFSET_Q = (SUM_W+1)'(GRAY_OFFSET) << GRAY_SHIFT;

  logic [SUM_W-1:0]   sum;
  logic [SUM_W:0]     diff;
  logic [SUM_W:0]     mag;
  logic [SUM_W:0]     quot;
  logic [GRAY_W-1:0]  quot8;
  logic [GRAY_W-1:0]  gray;
  logic               neg;

  logic               valid_r;
  logic [GRAY_W-1:0]  gray_r;
  logic [INDEX_W-1:0] index_r;
  logic               last_r;

  // Average of four, minus 128, truncated toward zero
  assign sum   = SUM_W'(s2_lum.luma[0]) + SUM_W'(s2_lum.luma[1]) +
                 SUM_W'(s2_lum.luma[2]) + SUM_W'(s2_lum.luma[3]);
  assign diff  = {1'b0, sum} - OFFSET_Q;
  assign neg   = diff[SUM_W];
  assign mag   = neg ? -diff : diff;
  assign quot  = mag >> GRAY_SHIFT;
  assign quot8 = quot[GRAY_W-1:0];
  assign gray  = neg ? -quot8 : quot8;

  assign out_en = !valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (out_en) begin
      valid_r <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_en && s2_valid) begin
      gray_r  <= gray;
      index_r <= s2_lum.index;
      last_r  <= s2_lum.last;
    end
  end

  assign out_ch.valid     = valid_r;
  assign out_ch.gray      = gray_r;
  assign out_ch.out_index = index_r;
  assign out_ch.last      = last_r;

endmodule

[rtl/core/rgb565_crop_scale_gray_int8_core.sv]
// RGB565 to signed 8-bit grayscale crop and downscale. Takes a raster-order
// frame, one pixel per transfer, with frame_start on the first pixel, and
// emits an OUT_SIZE x OUT_SIZE image in raster order: each result is the
// average Q16 luminance of a 2x2 capture window minus 128, with its output
// index (row * out_row_stride + column, wrapping at 17 bits) and a last flag
// on the final pixel. One pixel is taken every cycle when the result side
// is not stalled; the line store does one read and one write per pixel on
// its single port pair, which sets that rate. The result of a completed window
// passes through the window, luminance and output registers in that order. No
// clearing pass is needed after reset; frames must be delivered whole from
// frame_start. Write out_row_stride only while no transfer is in flight.
`include "assert_macros.svh"

module rgb565_crop_scale_gray_int8_core import csg_pkg::*; #(
  parameter int CAPTURE_WIDTH     = CAPTURE_WIDTH_DEF,
  parameter int CAPTURE_HEIGHT    = CAPTURE_HEIGHT_DEF,
  parameter int OUT_SIZE          = OUT_SIZE_DEF,
  parameter int CROP_LEFT         = CROP_LEFT_DEF,
  parameter int CROP_RIGHT_MARGIN = CROP_RIGHT_MARGIN_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  csg_pixel_if.sink           in_ch,
  csg_gray_if.source          out_ch,
  input  logic                cfg_we,
  input  logic [STRIDE_W-1:0] cfg_wdata
);

  logic [STRIDE_W-1:0] stride_r;
  logic                s1_valid;
  csg_win_t            s1_win;
  logic [PIXEL_W-1:0]  s1_above;
  logic                s2_en;
  logic                s2_valid;
  csg_lum_t            s2_lum;
  logic                out_en;

  // Output row pitch register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stride_r <= STRIDE_RESET;
    end else if (cfg_we) begin
      stride_r <= cfg_wdata;
    end
  end

  csg_front #(
    .CAPTURE_WIDTH     (CAPTURE_WIDTH),
    .CAPTURE_HEIGHT    (CAPTURE_HEIGHT),
    .OUT_SIZE          (OUT_SIZE),
    .CROP_LEFT         (CROP_LEFT),
    .CROP_RIGHT_MARGIN (CROP_RIGHT_MARGIN)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .s2_en    (s2_en),
    .s1_valid (s1_valid),
    .s1_win   (s1_win),
    .s1_above (s1_above)
  );

  csg_luma u_luma (
    .clk      (clk),
    .rst_n    (rst_n),
    .s1_valid (s1_valid),
    .s1_win   (s1_win),
    .s1_above (s1_above),
    .stride   (stride_r),
    .out_en   (out_en),
    .s2_en    (s2_en),
    .s2_valid (s2_valid),
    .s2_lum   (s2_lum)
  );

  csg_out u_out (
    .clk      (clk),
    .rst_n    (rst_n),
    .s2_valid (s2_valid),
    .s2_lum   (s2_lum),
    .out_en   (out_en),
    .out_ch   (out_ch)
  );

  // Input stalls only when every stage is full and the output is blocked
  `CSG_ASSERT_SAME(a_full_stall, s1_valid && s2_valid && out_ch.valid && !out_ch.ready, !in_ch.ready, "input ready while pipeline full and stalled")
  // A window that advances reaches the luminance stage
  `CSG_ASSERT_NEXT(a_s1_to_s2, s1_valid && s2_en, s2_valid, "window lost between stages")
  // A luminance entry that advances reaches the output register
  `CSG_ASSERT_NEXT(a_s2_to_out, s2_valid && out_en, out_ch.valid, "result lost before output")

endmodule
